@@ hw/rtl/lpht_pkg.sv @@
// Shared types, codes and fixed widths of the linear-probe hash table.
package lpht_pkg;

    // Fixed field widths.
    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int DIV_CNT_W = $clog2(KEY_W + 1);

    // Default number of slots and reset value of the size register.
    localparam int MAX_SLOTS_DEFAULT = 128;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 8'd128;

    // The size register cannot name more than this many slots.
    localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } lpht_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_FOUND     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_DELETED   = 3'd4
    } lpht_status_t;

    // Commands from the sequencer to the slot store.
    typedef struct packed {
        logic rd_en;
        logic wr_key;
        logic set_used;
        logic clr_used;
    } lpht_store_cmd_t;

endpackage

@@ hw/rtl/linear_probe_hash_table_core.sv @@
// Top level of the linear-probe hash table: request sequencer and result register.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_action[1:0], s_key_value[30:0]
//  m_       out        m_valid/m_ready    m_status[2:0], m_slot_index[6:0]
//  cfg_     in         cfg_wr_en          cfg_wr_data[7:0] (table size)
//
// A request passes through the serial remainder unit, probes the table at one key-memory read
// per cycle and has its result loaded into the output register. An unused action skips both
// and reports not found at slot 0. Reset is synchronous and active low; it empties the
// table and sets the size to 128. s_ready is high only in idle; a result may wait in the
// output register, but a finished request holds until it is free.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [SIZE_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [KEY_W-1:0]    s_key_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_index
);

    // Slots above what the size register can name are never reached.
    localparam int DEPTH = (MAX_SLOTS < SIZE_LIMIT) ? MAX_SLOTS : SIZE_LIMIT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    table_size_reg;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     chk_pos_reg, chk_pos_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [SIZE_W-1:0]    n_reg, n_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;

    logic [SIZE_W-1:0]    live_size;
    logic                 mod_start;
    logic                 mod_done;
    logic [SIZE_W-1:0]    mod_rem;
    lpht_store_cmd_t      cmd;
    logic [KEY_W-1:0]     rd_data;
    logic                 chk_used;
    logic                 is_insert;
    logic                 hit;
    logic [SIZE_W-1:0]    pos_wide;
    logic [SIZE_W-1:0]    chk_wide;

    // Size register, written directly from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RESET;
        end else if (cfg_wr_en) begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // A size of zero means one slot; a size beyond the table means all slots.
    always_comb begin
        if (table_size_reg == '0) begin
            live_size = SIZE_W'(1);
        end else if (table_size_reg > DEPTH_SZ) begin
            live_size = DEPTH_SZ;
        end else begin
            live_size = table_size_reg;
        end
    end

    lpht_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_key_value),
        .divisor   (live_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lpht_slot_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (pos_reg),
        .chk_addr (chk_pos_reg),
        .wr_data  (key_reg),
        .rd_data  (rd_data),
        .chk_used (chk_used)
    );

    // Compare of the slot read in the previous cycle.
    assign is_insert = (act_reg == ACT_INSERT);
    assign hit       = is_insert ? !chk_used : (chk_used && (rd_data == key_reg));
    assign pos_wide  = SIZE_W'(pos_reg);
    assign chk_wide  = SIZE_W'(chk_pos_reg);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        chk_pos_next    = chk_pos_reg;
        chk_vld_next    = chk_vld_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        mod_start       = 1'b0;
        cmd             = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next  = s_action;
                    key_next  = s_key_value;
                    size_next = live_size;
                    case (s_action)
                        ACT_INSERT, ACT_SEARCH, ACT_DELETE: begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                        default: begin
                            res_status_next = STS_NOT_FOUND;
                            res_slot_next   = '0;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end

            S_MOD: begin
                if (mod_done) begin
                    pos_next     = mod_rem[IDX_W-1:0];
                    n_next       = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_PROBE;
                end
            end

            S_PROBE: begin
                if (chk_vld_reg && hit) begin
                    // Slot found: update the table and report it.
                    res_slot_next = chk_wide[SLOT_W-1:0];
                    case (act_reg)
                        ACT_INSERT: begin
                            cmd.set_used    = 1'b1;
                            cmd.wr_key      = 1'b1;
                            res_status_next = STS_INSERTED;
                        end
                        ACT_DELETE: begin
                            cmd.clr_used    = 1'b1;
                            res_status_next = STS_DELETED;
                        end
                        default: begin
                            res_status_next = STS_FOUND;
                        end
                    endcase
                    state_next = S_FINISH;
                end else if (!chk_vld_reg && (n_reg == size_reg)) begin
                    // Every slot of the table size has been visited without success.
                    res_status_next = is_insert ? STS_OVERFLOW : STS_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = S_FINISH;
                end else begin
                    chk_vld_next = (n_reg < size_reg);
                    if (n_reg < size_reg) begin
                        cmd.rd_en    = 1'b1;
                        chk_pos_next = pos_reg;
                        n_next       = n_reg + 1'b1;
                        if (pos_wide == size_reg - 1'b1) begin
                            pos_next = '0;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end

            S_FINISH: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            chk_vld_reg <= chk_vld_next;
        end
        size_reg       <= size_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        chk_pos_reg    <= chk_pos_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_reg;

endmodule

@@ hw/rtl/lpht_mod_unit.sv @@
// Serial remainder unit: one restoring step per cycle over the key bits.
module lpht_mod_unit
    import lpht_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [KEY_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SIZE_W-1:0] remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [KEY_W-1:0]     dvd_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    div_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      trial_sub;

    // One restoring step: bring in the next key bit and subtract if it fits.
    assign trial     = {rem_reg, dvd_reg[KEY_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(KEY_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_reg <= trial_sub[SIZE_W-1:0];
            end else begin
                rem_reg <= trial[SIZE_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/lpht_slot_store.sv @@
// Slot store: occupancy flags in flip-flops and the key memory.
module lpht_slot_store
    import lpht_pkg::*;
#(
    parameter int DEPTH = MAX_SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lpht_store_cmd_t          cmd,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] chk_addr,
    input  logic [KEY_W-1:0]         wr_data,
    output logic [KEY_W-1:0]         rd_data,
    output logic                     chk_used
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] used_reg;
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Occupancy flags, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.set_used) begin
            used_reg[chk_addr] <= 1'b1;
        end else if (cmd.clr_used) begin
            used_reg[chk_addr] <= 1'b0;
        end
    end

    // Key memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_key) begin
            key_mem[chk_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= key_mem[rd_addr[IDX_W-1:0]];
        end
    end

    assign rd_data  = rd_data_reg;
    assign chk_used = used_reg[chk_addr];

endmodule
